// ===== src/dmpid_pkg.sv =====
// ----------------------------------------------------------------------------
// dmpid_pkg
// Shared types and constants of the dual mode PID motor power core.
// ----------------------------------------------------------------------------
package dmpid_pkg;

   // fixed point format and state widths
   localparam int FRAC_BITS    = 16;
   localparam int INTEG_W      = 48;
   localparam int INTEG_SUM_W  = INTEG_W + 2;
   localparam int VAL_W        = 32;
   localparam int GAIN_W       = 32;
   localparam int DT_W         = 20;
   localparam int POWER_W      = 8;

   // term and power arithmetic
   localparam int TERM_W       = 46;
   localparam int SUM_W        = TERM_W + 3;
   localparam int SCALE_W      = SUM_W + 7;
   localparam int POWER_MAX    = 100;

   // shared multiplier: 32x32, wide operand taken in two halves
   localparam int MUL_W        = 32;
   localparam int PROD_W       = 2 * MUL_W;
   localparam int BMAG_W       = 2 * MUL_W;
   localparam int ACC_W        = PROD_W + MUL_W;

   // shared divider: radix 4 restoring
   localparam int DIV_W        = 52;
   localparam int DIV_RADIX    = 2;
   localparam int DIV_STEPS    = DIV_W / DIV_RADIX;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
   localparam logic [DT_W-1:0] US_PER_S = 20'd1000000;

   // configuration
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 47;
   localparam int TOL_W        = 31;
   localparam int CAP_W        = 47;
   localparam int CMP_W        = 65;
   localparam logic MODE_VELOCITY = 1'b0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROP_GAIN  = 3'd0,
      CSR_INTEG_GAIN = 3'd1,
      CSR_DERIV_GAIN = 3'd2,
      CSR_ERR_TOL    = 3'd3,
      CSR_INTEG_CAP  = 3'd4,
      CSR_MODE       = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] proportional_gain;
      logic signed [GAIN_W-1:0] integral_gain;
      logic signed [GAIN_W-1:0] derivative_gain;
      logic [TOL_W-1:0]         error_tolerance;
      logic [CAP_W-1:0]         integral_cap;
      logic                     control_mode;
   } cfg_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] setpoint;
      logic signed [VAL_W-1:0] measured;
      logic [DT_W-1:0]         elapsed_us;
   } req_payload_type;

   typedef struct packed {
      logic signed [POWER_W-1:0] drive_power;
      logic                      power_clamped;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_MUL_INC,
      ST_DIV_INC_LD,
      ST_DIV_INC,
      ST_INTEG,
      ST_DIV_RATE_LD,
      ST_DIV_RATE,
      ST_RATE,
      ST_TERM_LO,
      ST_TERM_HI,
      ST_TERM_ACC,
      ST_TERM_ADD,
      ST_SCALE,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MUL_INC,
      MUL_RATE,
      MUL_TERM_LO,
      MUL_TERM_HI
   } mul_src_type;

   typedef enum logic [1:0] {
      TERM_P,
      TERM_I,
      TERM_D
   } term_sel_type;

   typedef struct packed {
      logic         load;
      logic         calc_err;
      logic         calc_derr;
      logic         mul_en;
      mul_src_type  mul_src;
      logic         div_load;
      logic         div_by_dt;
      logic         div_step;
      logic         integ_update;
      logic         rate_latch;
      term_sel_type term;
      logic         acc_load;
      logic         acc_add_hi;
      logic         term_add;
      logic         scale;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic dt_zero;
   } status_type;

endpackage

// ===== src/dmpid_csr.sv =====
// ----------------------------------------------------------------------------
// dmpid_csr
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module dmpid_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [dmpid_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dmpid_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output dmpid_pkg::cfg_type                 cfg
);

   dmpid_pkg::cfg_type cfg_ff;
   dmpid_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (dmpid_pkg::csr_index_type'(csr_index))
            dmpid_pkg::CSR_PROP_GAIN: begin
               cfg_in.proportional_gain = $signed(csr_wdata[dmpid_pkg::GAIN_W-1:0]);
            end
            dmpid_pkg::CSR_INTEG_GAIN: begin
               cfg_in.integral_gain = $signed(csr_wdata[dmpid_pkg::GAIN_W-1:0]);
            end
            dmpid_pkg::CSR_DERIV_GAIN: begin
               cfg_in.derivative_gain = $signed(csr_wdata[dmpid_pkg::GAIN_W-1:0]);
            end
            dmpid_pkg::CSR_ERR_TOL: begin
               cfg_in.error_tolerance = csr_wdata[dmpid_pkg::TOL_W-1:0];
            end
            dmpid_pkg::CSR_INTEG_CAP: begin
               cfg_in.integral_cap = csr_wdata[dmpid_pkg::CAP_W-1:0];
            end
            dmpid_pkg::CSR_MODE: begin
               cfg_in.control_mode = csr_wdata[0];
            end
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/dmpid_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmpid_ctrl
// Sequencer: steps one transaction through error, integral, rate, the three
// gain terms and the power scaling, and owns the result valid.
// ----------------------------------------------------------------------------
module dmpid_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  dmpid_pkg::status_type  status,
   output dmpid_pkg::cmd_type     cmd
);

   dmpid_pkg::state_type    state_ff, state_in;
   dmpid_pkg::term_sel_type term_ff, term_in;
   logic [dmpid_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   localparam logic [dmpid_pkg::DIV_CNT_W-1:0] CNT_LAST =
      dmpid_pkg::DIV_CNT_W'(dmpid_pkg::DIV_STEPS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dmpid_pkg::ST_IDLE;
         term_ff      <= dmpid_pkg::TERM_P;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      term_in      = term_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.term     = term_ff;
      req_stall    = 1'b1;

      case (state_ff)
         dmpid_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = dmpid_pkg::ST_ERR;
            end
         end
         dmpid_pkg::ST_ERR: begin
            cmd.calc_err = 1'b1;
            term_in      = dmpid_pkg::TERM_P;
            state_in     = dmpid_pkg::ST_MUL_INC;
         end
         dmpid_pkg::ST_MUL_INC: begin
            cmd.calc_derr = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_src   = dmpid_pkg::MUL_INC;
            state_in      = dmpid_pkg::ST_DIV_INC_LD;
         end
         dmpid_pkg::ST_DIV_INC_LD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = dmpid_pkg::ST_DIV_INC;
         end
         dmpid_pkg::ST_DIV_INC: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = dmpid_pkg::ST_INTEG;
            end
         end
         dmpid_pkg::ST_INTEG: begin
            cmd.integ_update = 1'b1;
            cmd.mul_en       = 1'b1;
            cmd.mul_src      = dmpid_pkg::MUL_RATE;
            // no interval: skip the rate division, rate is zero
            state_in = status.dt_zero ? dmpid_pkg::ST_RATE : dmpid_pkg::ST_DIV_RATE_LD;
         end
         dmpid_pkg::ST_DIV_RATE_LD: begin
            cmd.div_load  = 1'b1;
            cmd.div_by_dt = 1'b1;
            cnt_in        = '0;
            state_in      = dmpid_pkg::ST_DIV_RATE;
         end
         dmpid_pkg::ST_DIV_RATE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = dmpid_pkg::ST_RATE;
            end
         end
         dmpid_pkg::ST_RATE: begin
            cmd.rate_latch = 1'b1;
            state_in       = dmpid_pkg::ST_TERM_LO;
         end
         dmpid_pkg::ST_TERM_LO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_src = dmpid_pkg::MUL_TERM_LO;
            state_in    = dmpid_pkg::ST_TERM_HI;
         end
         dmpid_pkg::ST_TERM_HI: begin
            cmd.acc_load = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_src  = dmpid_pkg::MUL_TERM_HI;
            state_in     = dmpid_pkg::ST_TERM_ACC;
         end
         dmpid_pkg::ST_TERM_ACC: begin
            cmd.acc_add_hi = 1'b1;
            state_in       = dmpid_pkg::ST_TERM_ADD;
         end
         dmpid_pkg::ST_TERM_ADD: begin
            cmd.term_add = 1'b1;
            case (term_ff)
               dmpid_pkg::TERM_P: begin
                  term_in  = dmpid_pkg::TERM_I;
                  state_in = dmpid_pkg::ST_TERM_LO;
               end
               dmpid_pkg::TERM_I: begin
                  term_in  = dmpid_pkg::TERM_D;
                  state_in = dmpid_pkg::ST_TERM_LO;
               end
               default: begin
                  state_in = dmpid_pkg::ST_SCALE;
               end
            endcase
         end
         dmpid_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = dmpid_pkg::ST_OUT;
         end
         dmpid_pkg::ST_OUT: begin
            // hold until the result register is free or drains this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = dmpid_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dmpid_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/dmpid_dp.sv =====
// ----------------------------------------------------------------------------
// dmpid_dp
// Datapath: error, shared 32x32 multiplier, shared radix-4 divider, integral
// with saturation and clear rules, term accumulation and power scaling.
// ----------------------------------------------------------------------------
module dmpid_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  dmpid_pkg::cmd_type           cmd,
   output dmpid_pkg::status_type        status,
   input  dmpid_pkg::cfg_type           cfg,
   input  dmpid_pkg::req_payload_type   req_data,
   output dmpid_pkg::rsp_payload_type   rsp_data
);

   // state and payload registers
   dmpid_pkg::req_payload_type               in_ff;
   logic signed [dmpid_pkg::VAL_W-1:0]       err_ff, err_in;
   logic signed [dmpid_pkg::VAL_W-1:0]       last_err_ff;
   logic [dmpid_pkg::VAL_W-1:0]              derr_mag_ff, derr_mag_in;
   logic                                     derr_neg_ff, derr_neg_in;
   logic signed [dmpid_pkg::INTEG_W-1:0]     integ_ff, integ_in;
   logic [dmpid_pkg::DIV_W-1:0]              rate_mag_ff;
   logic                                     rate_neg_ff;
   logic [dmpid_pkg::PROD_W-1:0]             prod_ff, prod_in;
   logic [dmpid_pkg::ACC_W-1:0]              acc_ff;
   logic signed [dmpid_pkg::SUM_W-1:0]       sum_ff, sum_in;
   logic signed [dmpid_pkg::SCALE_W-1:0]     scaled_ff, scaled_in;
   logic [dmpid_pkg::DIV_W-1:0]              quo_ff, quo_in;
   logic [dmpid_pkg::DT_W-1:0]               rem_ff, rem_in;
   logic [dmpid_pkg::DT_W-1:0]               divisor_ff;
   dmpid_pkg::rsp_payload_type               rsp_ff, rsp_in;

   // error
   logic [dmpid_pkg::VAL_W:0]                diff;
   logic [dmpid_pkg::VAL_W-1:0]              err_mag;
   logic [dmpid_pkg::VAL_W:0]                derr, derr_neg_full;

   always_comb begin
      diff = {in_ff.setpoint[dmpid_pkg::VAL_W-1], in_ff.setpoint}
           - {in_ff.measured[dmpid_pkg::VAL_W-1], in_ff.measured};
      case (diff[dmpid_pkg::VAL_W:dmpid_pkg::VAL_W-1])
         2'b01:   err_in = $signed({1'b0, {(dmpid_pkg::VAL_W-1){1'b1}}});
         2'b10:   err_in = $signed({1'b1, {(dmpid_pkg::VAL_W-1){1'b0}}});
         default: err_in = $signed(diff[dmpid_pkg::VAL_W-1:0]);
      endcase

      err_mag = err_ff[dmpid_pkg::VAL_W-1] ? (~err_ff + 1'b1) : err_ff;

      derr = {err_ff[dmpid_pkg::VAL_W-1], err_ff}
           - {last_err_ff[dmpid_pkg::VAL_W-1], last_err_ff};
      derr_neg_full = ~derr + 1'b1;
      derr_neg_in   = derr[dmpid_pkg::VAL_W];
      derr_mag_in   = derr_neg_in ? derr_neg_full[dmpid_pkg::VAL_W-1:0]
                                  : derr[dmpid_pkg::VAL_W-1:0];
   end

   // term operand selection
   logic signed [dmpid_pkg::GAIN_W-1:0]      gain;
   logic [dmpid_pkg::GAIN_W-1:0]             gain_mag;
   logic [dmpid_pkg::BMAG_W-1:0]             b_mag;
   logic                                     b_neg;
   logic [dmpid_pkg::INTEG_W-1:0]            integ_mag;

   always_comb begin
      integ_mag = integ_ff[dmpid_pkg::INTEG_W-1] ? (~integ_ff + 1'b1) : integ_ff;
      case (cmd.term)
         dmpid_pkg::TERM_P: begin
            gain  = cfg.proportional_gain;
            b_mag = dmpid_pkg::BMAG_W'(err_mag);
            b_neg = err_ff[dmpid_pkg::VAL_W-1];
         end
         dmpid_pkg::TERM_I: begin
            gain  = cfg.integral_gain;
            b_mag = dmpid_pkg::BMAG_W'(integ_mag);
            b_neg = integ_ff[dmpid_pkg::INTEG_W-1];
         end
         default: begin
            gain  = cfg.derivative_gain;
            b_mag = dmpid_pkg::BMAG_W'(rate_mag_ff);
            b_neg = rate_neg_ff;
         end
      endcase
      gain_mag = gain[dmpid_pkg::GAIN_W-1] ? (~gain + 1'b1) : gain;
   end

   // shared multiplier
   logic [dmpid_pkg::MUL_W-1:0] mul_a, mul_b;

   always_comb begin
      case (cmd.mul_src)
         dmpid_pkg::MUL_INC: begin
            mul_a = err_mag;
            mul_b = dmpid_pkg::MUL_W'(in_ff.elapsed_us);
         end
         dmpid_pkg::MUL_RATE: begin
            mul_a = derr_mag_ff;
            mul_b = dmpid_pkg::MUL_W'(dmpid_pkg::US_PER_S);
         end
         dmpid_pkg::MUL_TERM_LO: begin
            mul_a = gain_mag;
            mul_b = b_mag[dmpid_pkg::MUL_W-1:0];
         end
         default: begin
            mul_a = gain_mag;
            mul_b = b_mag[dmpid_pkg::BMAG_W-1:dmpid_pkg::MUL_W];
         end
      endcase
      prod_in = dmpid_pkg::PROD_W'(mul_a) * dmpid_pkg::PROD_W'(mul_b);
   end

   // shared divider, two quotient bits per step
   logic [dmpid_pkg::DT_W:0] div_trial;

   always_comb begin
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_trial = '0;
      for (int i = 0; i < dmpid_pkg::DIV_RADIX; i++) begin
         div_trial = {rem_in, quo_in[dmpid_pkg::DIV_W-1]};
         quo_in    = {quo_in[dmpid_pkg::DIV_W-2:0], 1'b0};
         if (div_trial >= {1'b0, divisor_ff}) begin
            div_trial = div_trial - {1'b0, divisor_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = div_trial[dmpid_pkg::DT_W-1:0];
      end
   end

   // integral update: saturating add, then velocity-mode clear rules
   logic [dmpid_pkg::INTEG_SUM_W-1:0]        inc_ext;
   logic signed [dmpid_pkg::INTEG_SUM_W-1:0] inc_s, isum;
   logic [2:0]                               isum_top;
   logic signed [dmpid_pkg::INTEG_W-1:0]     integ_sat;
   logic                                     velocity;

   always_comb begin
      velocity = (cfg.control_mode == dmpid_pkg::MODE_VELOCITY);
      inc_ext  = dmpid_pkg::INTEG_SUM_W'(quo_ff[dmpid_pkg::VAL_W-1:0]);
      inc_s    = err_ff[dmpid_pkg::VAL_W-1] ? $signed(~inc_ext + 1'b1) : $signed(inc_ext);
      isum     = $signed({{2{integ_ff[dmpid_pkg::INTEG_W-1]}}, integ_ff}) + inc_s;
      isum_top = isum[dmpid_pkg::INTEG_SUM_W-1:dmpid_pkg::INTEG_W-1];
      if ((&isum_top) || !(|isum_top)) begin
         integ_sat = isum[dmpid_pkg::INTEG_W-1:0];
      end else if (isum[dmpid_pkg::INTEG_SUM_W-1]) begin
         integ_sat = $signed({1'b1, {(dmpid_pkg::INTEG_W-1){1'b0}}});
      end else begin
         integ_sat = $signed({1'b0, {(dmpid_pkg::INTEG_W-1){1'b1}}});
      end

      if (velocity && (err_mag <= dmpid_pkg::VAL_W'(cfg.error_tolerance))) begin
         integ_in = '0;
      end else begin
         integ_in = integ_sat;
      end
      // only a positive excess over the cap clears
      if (velocity && ($signed(dmpid_pkg::CMP_W'(integ_in))
                       > $signed(dmpid_pkg::CMP_W'(cfg.integral_cap)))) begin
         integ_in = '0;
      end
   end

   // term: shift out the fraction, saturate magnitude, apply sign, accumulate
   logic [dmpid_pkg::ACC_W-1:0]        acc_shift;
   logic [dmpid_pkg::TERM_W-1:0]       term_mag;
   logic [dmpid_pkg::SUM_W-1:0]        term_ext;
   logic signed [dmpid_pkg::SUM_W-1:0] term_val;
   logic signed [dmpid_pkg::SCALE_W-1:0] sum_ext;

   always_comb begin
      acc_shift = acc_ff >> dmpid_pkg::FRAC_BITS;
      term_mag  = (|acc_shift[dmpid_pkg::ACC_W-1:dmpid_pkg::TERM_W])
                ? {dmpid_pkg::TERM_W{1'b1}} : acc_shift[dmpid_pkg::TERM_W-1:0];
      term_ext  = dmpid_pkg::SUM_W'(term_mag);
      term_val  = (gain[dmpid_pkg::GAIN_W-1] ^ b_neg) ? $signed(~term_ext + 1'b1)
                                                      : $signed(term_ext);
      sum_in    = sum_ff + term_val;
      // times 100 as 64 + 32 + 4
      sum_ext   = dmpid_pkg::SCALE_W'(sum_ff);
      scaled_in = (sum_ext <<< 6) + (sum_ext <<< 5) + (sum_ext <<< 2);
   end

   // power: divide by 2^FRAC_BITS toward zero, clamp
   logic signed [dmpid_pkg::SCALE_W-1:0] pow_bias, pow_q, pow_hi, pow_lo;

   always_comb begin
      pow_hi   = $signed(dmpid_pkg::SCALE_W'(dmpid_pkg::POWER_MAX));
      pow_lo   = -pow_hi;
      pow_bias = scaled_ff[dmpid_pkg::SCALE_W-1]
               ? $signed(dmpid_pkg::SCALE_W'((1 << dmpid_pkg::FRAC_BITS) - 1)) : '0;
      pow_q    = (scaled_ff + pow_bias) >>> dmpid_pkg::FRAC_BITS;
      if (pow_q > pow_hi) begin
         rsp_in.drive_power   = dmpid_pkg::POWER_W'(dmpid_pkg::POWER_MAX);
         rsp_in.power_clamped = 1'b1;
      end else if (pow_q < pow_lo) begin
         rsp_in.drive_power   = dmpid_pkg::POWER_W'(-dmpid_pkg::POWER_MAX);
         rsp_in.power_clamped = 1'b1;
      end else begin
         rsp_in.drive_power   = pow_q[dmpid_pkg::POWER_W-1:0];
         rsp_in.power_clamped = 1'b0;
      end
   end

   // controller-visible state
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         last_err_ff <= '0;
      end else begin
         if (cmd.integ_update) begin
            integ_ff <= integ_in;
         end
         if (cmd.calc_derr) begin
            last_err_ff <= err_ff;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_ff <= req_data;
      end
      if (cmd.calc_err) begin
         err_ff <= err_in;
         sum_ff <= '0;
      end
      if (cmd.calc_derr) begin
         derr_mag_ff <= derr_mag_in;
         derr_neg_ff <= derr_neg_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.div_load) begin
         quo_ff     <= prod_ff[dmpid_pkg::DIV_W-1:0];
         rem_ff     <= '0;
         divisor_ff <= cmd.div_by_dt ? in_ff.elapsed_us : dmpid_pkg::US_PER_S;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.rate_latch) begin
         rate_mag_ff <= status.dt_zero ? '0 : quo_ff;
         rate_neg_ff <= derr_neg_ff;
      end
      if (cmd.acc_load) begin
         acc_ff <= dmpid_pkg::ACC_W'(prod_ff);
      end else if (cmd.acc_add_hi) begin
         acc_ff <= acc_ff + {prod_ff, {dmpid_pkg::MUL_W{1'b0}}};
      end
      if (cmd.term_add) begin
         sum_ff <= sum_in;
      end
      if (cmd.scale) begin
         scaled_ff <= scaled_in;
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.dt_zero = (in_ff.elapsed_us == '0);
   assign rsp_data       = rsp_ff;

endmodule

// ===== src/dual_mode_pid_motor_power_core.sv =====
// ----------------------------------------------------------------------------
// dual_mode_pid_motor_power_core
// PID motor power controller in Q16.16 with velocity/position integral modes.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  setpoint, measured, elapsed_us
//   rsp_     out        rsp_valid/rsp_stall  drive_power, power_clamped
//   csr_     in         csr_write            csr_index, csr_wdata
//
// One transaction at a time; the run time is set by the shared radix-4
// divider (26 steps for the integral increment, 26 for the rate, which is
// skipped when elapsed_us is zero) and the shared 32x32 multiplier (two
// passes per gain term).
// Reset is synchronous and clears the configuration, sequencer, integral and last error.
// A result waits in the output register under rsp_stall; the next
// transaction is accepted meanwhile and holds only at its own output step.
// ----------------------------------------------------------------------------
module dual_mode_pid_motor_power_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  dmpid_pkg::req_payload_type         req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output dmpid_pkg::rsp_payload_type         rsp_data,
   input  logic                               csr_write,
   input  logic [dmpid_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dmpid_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   dmpid_pkg::cfg_type    cfg;
   dmpid_pkg::cmd_type    cmd;
   dmpid_pkg::status_type status;

   dmpid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dmpid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dmpid_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .cfg       (cfg),
      .req_data  (req_data),
      .rsp_data  (rsp_data)
   );

   // a stalled result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten while stalled");

   // payload captured only on an accepted transaction
   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_valid && !req_stall))
      else $error("payload captured without accept");

   // busy after capture
   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> req_stall)
      else $error("input not stalled after accept");

   // clamp flag only with a full-scale power
   a_clamp_full_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.power_clamped) |->
         (rsp_data.drive_power == 8'sd100 || rsp_data.drive_power == -8'sd100))
      else $error("clamp flag without full-scale power");

endmodule
